// File: src/timed_pump_block_sequencer_macros.svh
// Assertion macros used by the checker file of the pump block sequencer
`ifndef TIMED_PUMP_BLOCK_SEQUENCER_MACROS_SVH
`define TIMED_PUMP_BLOCK_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define TPBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication after a fixed number of cycles
`define TPBS_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) else $error(msg);

`endif

// File: src/tpbs_pkg.sv
// Types, constants and the control program of the pump block sequencer
package tpbs_pkg;

  localparam int TABLE_BLOCKS = 64;
  localparam int PUMP_COUNT   = 8;

  localparam int BLK_W  = $clog2(TABLE_BLOCKS);
  localparam int PW     = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;
  localparam int FLOW_W = 16;
  localparam int PC_W   = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [15:0]        GAIN_RST   = 16'd1232;
  localparam logic signed [23:0] OFFSET_RST = -24'sd34000;
  localparam logic [22:0]        VMIN_RST   = 23'd34000;
  localparam logic [22:0]        VMAX_RST   = 23'd4870000;

  typedef enum logic [2:0] {
    K_CLEAR, K_ST_HDR, K_ST_FLOW, K_START, K_STOP, K_TICK
  } kind_t;

  typedef enum logic [1:0] {
    OK_ENABLE, OK_DIR, OK_VOLT, OK_ACK
  } okind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN, REG_OFFSET, REG_VMIN, REG_VMAX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_ZERO, B_DIR, B_EN
  } bsel_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_CLEAR, ACT_STOP, ACT_ST_HDR, ACT_ST_FLOW, ACT_START,
    ACT_READ, ACT_MUL, ACT_ADD, ACT_ADVANCE
  } act_t;

  typedef enum logic [2:0] {
    C_NONE, C_ALWAYS, C_PUMP_MORE, C_SLOT0_INV, C_NOT_RUNNING, C_CUR_INV,
    C_NOT_ELAPSED, C_NEXT_BAD
  } cond_t;

  typedef struct packed {
    logic             emit;
    okind_t           okind;
    bsel_t            bsel;
    logic             vcalc;
    act_t             act;
    logic             pclr;
    logic             pinc;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             fin;
  } ctl_t;

  typedef struct packed {
    logic mul;
    logic add;
  } volt_ctl_t;

  typedef struct packed {
    logic [31:0] dur;
    logic [7:0]  dir;
    logic [7:0]  en;
  } hdr_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_END    = 5'd0;
  localparam logic [PC_W-1:0] PC_CLEAR  = 5'd1;
  localparam logic [PC_W-1:0] PC_STOP   = 5'd2;
  localparam logic [PC_W-1:0] PC_STOP_V = 5'd3;
  localparam logic [PC_W-1:0] PC_HDR    = 5'd4;
  localparam logic [PC_W-1:0] PC_FLOW   = 5'd5;
  localparam logic [PC_W-1:0] PC_ACK    = 5'd6;
  localparam logic [PC_W-1:0] PC_START  = 5'd7;
  localparam logic [PC_W-1:0] PC_APPLY  = 5'd8;
  localparam logic [PC_W-1:0] PC_DIR_A  = 5'd9;
  localparam logic [PC_W-1:0] PC_DIR_B  = 5'd10;
  localparam logic [PC_W-1:0] PC_MUL    = 5'd11;
  localparam logic [PC_W-1:0] PC_ADD    = 5'd12;
  localparam logic [PC_W-1:0] PC_VOLT   = 5'd13;
  localparam logic [PC_W-1:0] PC_EN_A   = 5'd14;
  localparam logic [PC_W-1:0] PC_EN_B   = 5'd15;
  localparam logic [PC_W-1:0] PC_TICK   = 5'd16;
  localparam logic [PC_W-1:0] PC_T_CUR  = 5'd17;
  localparam logic [PC_W-1:0] PC_T_TIME = 5'd18;
  localparam logic [PC_W-1:0] PC_T_NEXT = 5'd19;
  localparam logic [PC_W-1:0] PC_T_ADV  = 5'd20;

  function automatic logic [PC_W-1:0] entry_pc(logic [2:0] k);
    logic [PC_W-1:0] a;
    case (k)
      K_CLEAR:   a = PC_CLEAR;
      K_ST_HDR:  a = PC_HDR;
      K_ST_FLOW: a = PC_FLOW;
      K_START:   a = PC_START;
      K_STOP:    a = PC_STOP;
      K_TICK:    a = PC_TICK;
      default:   a = PC_END;
    endcase
    return a;
  endfunction

  function automatic ctl_t rom_word(logic [PC_W-1:0] pc);
    ctl_t w;
    w = '0;
    case (pc)
      PC_END: begin
        w.fin = 1'b1;
      end
      PC_CLEAR: begin
        w.act = ACT_CLEAR;
        w.cond = C_ALWAYS;
        w.target = PC_STOP;
      end
      PC_STOP: begin
        w.act = ACT_STOP;
        w.pclr = 1'b1;
        w.emit = 1'b1;
        w.okind = OK_ENABLE;
      end
      PC_STOP_V: begin
        w.emit = 1'b1;
        w.okind = OK_VOLT;
        w.pinc = 1'b1;
        w.cond = C_PUMP_MORE;
        w.target = PC_STOP_V;
        w.fin = 1'b1;
      end
      PC_HDR: begin
        w.act = ACT_ST_HDR;
        w.cond = C_ALWAYS;
        w.target = PC_ACK;
      end
      PC_FLOW: begin
        w.act = ACT_ST_FLOW;
      end
      PC_ACK: begin
        w.emit = 1'b1;
        w.okind = OK_ACK;
        w.fin = 1'b1;
      end
      PC_START: begin
        w.act = ACT_START;
        w.cond = C_SLOT0_INV;
        w.target = PC_END;
      end
      PC_APPLY: begin
        w.act = ACT_READ;
        w.pclr = 1'b1;
        w.emit = 1'b1;
        w.okind = OK_ENABLE;
      end
      PC_DIR_A, PC_DIR_B: begin
        w.emit = 1'b1;
        w.okind = OK_DIR;
        w.bsel = B_DIR;
      end
      PC_MUL: begin
        w.act = ACT_MUL;
      end
      PC_ADD: begin
        w.act = ACT_ADD;
      end
      PC_VOLT: begin
        w.emit = 1'b1;
        w.okind = OK_VOLT;
        w.vcalc = 1'b1;
        w.pinc = 1'b1;
        w.cond = C_PUMP_MORE;
        w.target = PC_MUL;
      end
      PC_EN_A: begin
        w.emit = 1'b1;
        w.okind = OK_ENABLE;
        w.bsel = B_EN;
      end
      PC_EN_B: begin
        w.emit = 1'b1;
        w.okind = OK_ENABLE;
        w.bsel = B_EN;
        w.fin = 1'b1;
      end
      PC_TICK: begin
        w.act = ACT_READ;
        w.cond = C_NOT_RUNNING;
        w.target = PC_END;
      end
      PC_T_CUR: begin
        w.cond = C_CUR_INV;
        w.target = PC_STOP;
      end
      PC_T_TIME: begin
        w.cond = C_NOT_ELAPSED;
        w.target = PC_END;
      end
      PC_T_NEXT: begin
        w.cond = C_NEXT_BAD;
        w.target = PC_STOP;
      end
      PC_T_ADV: begin
        w.act = ACT_ADVANCE;
        w.cond = C_ALWAYS;
        w.target = PC_APPLY;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/tpbs_volt.sv
// Flow to voltage unit: multiply, add offset, clamp
module tpbs_volt import tpbs_pkg::*; (
  input  logic                 clk,
  input  volt_ctl_t            ctl,
  input  logic [15:0]          gain,
  input  logic signed [23:0]   offset,
  input  logic [22:0]          vmin,
  input  logic [22:0]          vmax,
  input  logic [FLOW_W-1:0]    flow,
  output logic [22:0]          vout
);

  logic [31:0]        prod;
  logic signed [33:0] v;
  logic signed [33:0] vmin_s;
  logic signed [33:0] vmax_s;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= gain * flow;
    end
    if (ctl.add) begin
      v <= $signed({2'b00, prod}) + 34'(offset);
    end
  end

  assign vmin_s = $signed({11'b0, vmin});
  assign vmax_s = $signed({11'b0, vmax});

  // Low clamp wins when the limits cross
  always_comb begin
    if (v < vmin_s) begin
      vout = vmin;
    end else if (v > vmax_s) begin
      vout = vmax;
    end else begin
      vout = v[22:0];
    end
  end

endmodule

// File: src/timed_pump_block_sequencer.sv
// Top level of the timed pump block sequencer
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// request  | start, busy          | kind, slot_index, pump_index, hold_ms,
//          |                      | direction_mask, enable_mask, flow_value, now_ms
// result   | strobe (one cycle)   | out_kind, pump_number, byte_value, vout_uv,
//          |                      | status, blocks_loaded, last
// config   | cfg_write            | cfg_index, cfg_data
//
// A request runs a short program from the control table, one step a cycle; each
// result is registered at the step that makes it and appears in the cycle after.
// Each pump of an apply takes three steps (multiply, offset, clamp). Reset clears
// all valid bits, the counters, the configuration, strobe and the control state;
// the captured request, read and result payload registers are not reset. Results
// cannot be held off; busy alone paces requests.
module timed_pump_block_sequencer import tpbs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             kind,
  input  logic [7:0]             slot_index,
  input  logic [3:0]             pump_index,
  input  logic [31:0]            hold_ms,
  input  logic [7:0]             direction_mask,
  input  logic [7:0]             enable_mask,
  input  logic [15:0]            flow_value,
  input  logic [31:0]            now_ms,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   strobe,
  output logic [1:0]             out_kind,
  output logic [2:0]             pump_number,
  output logic [7:0]             byte_value,
  output logic [22:0]            vout_uv,
  output logic                   status,
  output logic [7:0]             blocks_loaded,
  output logic                   last
);

  // Configuration
  logic [15:0]        gain;
  logic signed [23:0] offset;
  logic [22:0]        vmin;
  logic [22:0]        vmax;

  // Sequencer state
  logic               active;
  logic [PC_W-1:0]    pc;
  logic [PW-1:0]      p;
  logic [BLK_W-1:0]   cur;
  logic [31:0]        start_time;
  logic               running;
  logic [7:0]         loaded;
  logic [TABLE_BLOCKS-1:0] blk_valid;
  logic [TABLE_BLOCKS-1:0] row_valid;
  logic               st_bad;

  // Captured request
  logic [7:0]         q_block;
  logic [3:0]         q_pump;
  logic [31:0]        q_dur;
  logic [7:0]         q_dir;
  logic [7:0]         q_en;
  logic [15:0]        q_flow;
  logic [31:0]        q_now;

  // Memories and their read registers
  hdr_t               hdr_mem [TABLE_BLOCKS];
  logic [FLOW_W-1:0]  flow_mem [TABLE_BLOCKS][PUMP_COUNT];
  hdr_t               hdr_q;
  logic [FLOW_W-1:0]  row_q [PUMP_COUNT];
  logic               rowv_q;

  ctl_t               ctl;
  logic               taken;
  logic               fin_now;
  logic               blk_ok;
  logic               pump_ok;
  logic [BLK_W-1:0]   bi;
  logic [PW-1:0]      pi;
  logic [BLK_W-1:0]   nxt;
  logic               next_bad;
  logic [31:0]        elapsed;
  logic [31:0]        dur_eff;
  logic               hdr_we;
  logic               flow_we;
  logic [PUMP_COUNT-1:0] lane_we;
  logic [FLOW_W-1:0]  lane_wd [PUMP_COUNT];
  logic [FLOW_W-1:0]  flow_sel;
  logic [22:0]        vcalc;
  volt_ctl_t          vctl;
  logic [7:0]         byte_next;

  assign busy = active;
  assign ctl  = rom_word(pc);

  assign bi      = q_block[BLK_W-1:0];
  assign pi      = q_pump[PW-1:0];
  assign blk_ok  = q_block < 8'(TABLE_BLOCKS);
  assign pump_ok = q_pump < 4'(PUMP_COUNT);
  assign nxt     = cur + BLK_W'(1);
  assign next_bad = (cur == BLK_W'(TABLE_BLOCKS - 1)) || !blk_valid[nxt];
  assign elapsed = q_now - start_time;
  assign dur_eff = (hdr_q.dur == 32'd0) ? 32'd1 : hdr_q.dur;

  assign hdr_we  = active && (ctl.act == ACT_ST_HDR) && blk_ok;
  assign flow_we = active && (ctl.act == ACT_ST_FLOW) && blk_ok && pump_ok;

  always_comb begin
    case (ctl.cond)
      C_NONE:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_PUMP_MORE:   taken = p != PW'(PUMP_COUNT - 1);
      C_SLOT0_INV:   taken = !blk_valid[0];
      C_NOT_RUNNING: taken = !running;
      C_CUR_INV:     taken = !blk_valid[cur];
      C_NOT_ELAPSED: taken = elapsed < dur_eff;
      C_NEXT_BAD:    taken = next_bad;
      default:       taken = 1'b0;
    endcase
  end

  assign fin_now = ctl.fin && !taken;

  // First write into an untouched row zeroes its other lanes
  always_comb begin
    for (int l = 0; l < PUMP_COUNT; l++) begin
      lane_we[l] = flow_we && (!row_valid[bi] || (pi == PW'(l)));
      lane_wd[l] = (pi == PW'(l)) ? q_flow : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[bi] <= '{dur: q_dur, dir: q_dir, en: q_en};
    end
    for (int l = 0; l < PUMP_COUNT; l++) begin
      if (lane_we[l]) begin
        flow_mem[bi][l] <= lane_wd[l];
      end
    end
    if (active && ctl.act == ACT_READ) begin
      hdr_q  <= hdr_mem[cur];
      row_q  <= flow_mem[cur];
      rowv_q <= row_valid[cur];
    end
  end

  assign flow_sel = rowv_q ? row_q[p] : '0;
  assign vctl = '{mul: active && (ctl.act == ACT_MUL), add: active && (ctl.act == ACT_ADD)};

  tpbs_volt u_volt (
    .clk    (clk),
    .ctl    (vctl),
    .gain   (gain),
    .offset (offset),
    .vmin   (vmin),
    .vmax   (vmax),
    .flow   (flow_sel),
    .vout   (vcalc)
  );

  always_comb begin
    case (ctl.bsel)
      B_DIR:   byte_next = hdr_q.dir;
      B_EN:    byte_next = hdr_q.en;
      default: byte_next = 8'd0;
    endcase
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_block <= slot_index;
      q_pump  <= pump_index;
      q_dur   <= hold_ms;
      q_dir   <= direction_mask;
      q_en    <= enable_mask;
      q_flow  <= flow_value;
      q_now   <= now_ms;
    end
    if (active && (ctl.act == ACT_ST_HDR)) begin
      st_bad <= !blk_ok;
    end else if (active && (ctl.act == ACT_ST_FLOW)) begin
      st_bad <= !(blk_ok && pump_ok);
    end
    if (active && ctl.emit) begin
      out_kind      <= ctl.okind;
      pump_number   <= (ctl.okind == OK_VOLT) ? 3'(p) : 3'd0;
      byte_value    <= byte_next;
      vout_uv       <= ctl.vcalc ? vcalc : 23'd0;
      status        <= (ctl.okind == OK_ACK) ? st_bad : 1'b0;
      blocks_loaded <= (ctl.okind == OK_ACK) ? loaded : 8'd0;
      last          <= fin_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= GAIN_RST;
      offset     <= OFFSET_RST;
      vmin       <= VMIN_RST;
      vmax       <= VMAX_RST;
      active     <= 1'b0;
      pc         <= PC_END;
      p          <= '0;
      cur        <= '0;
      start_time <= 32'd0;
      running    <= 1'b0;
      loaded     <= 8'd0;
      blk_valid  <= '0;
      row_valid  <= '0;
      strobe     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN:   gain   <= cfg_data[15:0];
          REG_OFFSET: offset <= $signed(cfg_data[23:0]);
          REG_VMIN:   vmin   <= cfg_data[22:0];
          REG_VMAX:   vmax   <= cfg_data[22:0];
          default: ;
        endcase
      end

      strobe <= active && ctl.emit;

      if (start && !busy) begin
        active <= 1'b1;
        pc     <= entry_pc(kind);
      end else if (active) begin
        pc <= taken ? ctl.target : pc + PC_W'(1);
        if (fin_now) begin
          active <= 1'b0;
        end
      end

      if (active && ctl.pclr) begin
        p <= '0;
      end else if (active && ctl.pinc) begin
        p <= p + PW'(1);
      end

      if (active) begin
        case (ctl.act)
          ACT_CLEAR: begin
            blk_valid <= '0;
            row_valid <= '0;
            loaded    <= 8'd0;
          end
          ACT_STOP: begin
            running <= 1'b0;
          end
          ACT_ST_HDR: begin
            if (blk_ok) begin
              blk_valid[bi] <= 1'b1;
              if (!blk_valid[bi]) begin
                loaded <= loaded + 8'd1;
              end
            end
          end
          ACT_ST_FLOW: begin
            if (blk_ok && pump_ok) begin
              row_valid[bi] <= 1'b1;
            end
          end
          ACT_START: begin
            if (blk_valid[0]) begin
              running    <= 1'b1;
              cur        <= '0;
              start_time <= q_now;
            end else begin
              running <= 1'b0;
            end
          end
          ACT_ADVANCE: begin
            cur        <= nxt;
            start_time <= q_now;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: src/tpbs_checker.sv
// Port-level checks of the pump block sequencer and their bind
`include "timed_pump_block_sequencer_macros.svh"

module tpbs_checker import tpbs_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] kind,
  input logic       strobe,
  input logic [1:0] out_kind,
  input logic       last
);

  `TPBS_ASSERT_IMP(a_strobe_after_busy, strobe, $past(busy), "result without a running request")
  `TPBS_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe, "result right after a final one")
  `TPBS_ASSERT_IMP(a_ack_alone, strobe && out_kind == OK_ACK, last, "store ack not final")
  `TPBS_ASSERT_DELAY(a_ack_timing, start && !busy && (kind == K_ST_HDR || kind == K_ST_FLOW), 3, strobe && out_kind == OK_ACK, "store ack missing")

endmodule

bind timed_pump_block_sequencer tpbs_checker u_tpbs_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .kind     (kind),
  .strobe   (strobe),
  .out_kind (out_kind),
  .last     (last)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the timed pump block sequencer
`timescale 1ns / 1ps

module testbench;
  import tpbs_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  blk;
    logic [3:0]  pump;
    logic [31:0] dur;
    logic [7:0]  dir;
    logic [7:0]  en;
    logic [15:0] flow;
    logic [31:0] clock_ms;
  } pump_request_t;

  typedef struct packed {
    okind_t      kind;
    logic [2:0]  pump;
    logic [7:0]  byte_val;
    logic [22:0] uv;
    logic        status;
    logic [7:0]  loaded;
    logic        last;
  } pump_output_t;

  typedef struct packed {
    pump_request_t req;
    bit            typed;
    logic          status;
    logic [7:0]    loaded;
  } directed_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [2:0]            kind;
  logic [7:0]            slot_index;
  logic [3:0]            pump_index;
  logic [31:0]           hold_ms;
  logic [7:0]            direction_mask;
  logic [7:0]            enable_mask;
  logic [15:0]           flow_value;
  logic [31:0]           now_ms;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  strobe;
  logic [1:0]            out_kind;
  logic [2:0]            pump_number;
  logic [7:0]            byte_value;
  logic [22:0]           vout_uv;
  logic                  status;
  logic [7:0]            blocks_loaded;
  logic                  last;

  timed_pump_block_sequencer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .slot_index(slot_index), .pump_index(pump_index),
    .hold_ms(hold_ms), .direction_mask(direction_mask),
    .enable_mask(enable_mask), .flow_value(flow_value), .now_ms(now_ms),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .out_kind(out_kind), .pump_number(pump_number),
    .byte_value(byte_value), .vout_uv(vout_uv), .status(status),
    .blocks_loaded(blocks_loaded), .last(last)
  );

  // Sequencer image kept alongside the block
  logic [31:0] dur_tbl [TABLE_BLOCKS];
  logic [7:0]  dir_tbl [TABLE_BLOCKS];
  logic [7:0]  en_tbl [TABLE_BLOCKS];
  logic [15:0] flow_tbl [TABLE_BLOCKS * PUMP_COUNT];
  bit          valid_tbl [TABLE_BLOCKS];
  bit          seq_running;
  logic [7:0]  seq_block;
  logic [31:0] seq_t0;
  logic [7:0]  loaded_n;
  logic [15:0] gain_uv;
  int          offset_uv;
  logic [22:0] vmin_uv;
  logic [22:0] vmax_uv;

  pump_output_t  step_outputs[$];
  pump_output_t  pending_outputs[$];
  pump_output_t  want_out;
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            items_sent = 0;
  bit            steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void wipe_tables();
    foreach (dur_tbl[i]) begin
      dur_tbl[i]   = '0;
      dir_tbl[i]   = '0;
      en_tbl[i]    = '0;
      valid_tbl[i] = 1'b0;
    end
    foreach (flow_tbl[i]) flow_tbl[i] = '0;
    loaded_n = '0;
  endfunction

  function automatic void add_output(okind_t k, logic [2:0] p, logic [7:0] bv,
                                     logic [22:0] uv, logic st, logic [7:0] ld);
    pump_output_t x;
    x.kind     = k;
    x.pump     = p;
    x.byte_val = bv;
    x.uv       = uv;
    x.status   = st;
    x.loaded   = ld;
    x.last     = 1'b0;
    step_outputs.push_back(x);
  endfunction

  function automatic void add_shutdown();
    int p;
    seq_running = 1'b0;
    add_output(OK_ENABLE, 3'd0, 8'd0, 23'd0, 1'b0, 8'd0);
    for (p = 0; p < PUMP_COUNT; p++) add_output(OK_VOLT, 3'(p), 8'd0, 23'd0, 1'b0, 8'd0);
  endfunction

  function automatic void add_block_outputs(int b);
    int p;
    longint v;
    longint f;
    add_output(OK_ENABLE, 3'd0, 8'd0, 23'd0, 1'b0, 8'd0);
    add_output(OK_DIR, 3'd0, dir_tbl[b], 23'd0, 1'b0, 8'd0);
    add_output(OK_DIR, 3'd0, dir_tbl[b], 23'd0, 1'b0, 8'd0);
    for (p = 0; p < PUMP_COUNT; p++) begin
      f = flow_tbl[b * PUMP_COUNT + p];
      v = gain_uv;
      v = v * f + offset_uv;
      // low clamp wins when the limits cross
      if (v < longint'(vmin_uv)) v = vmin_uv;
      else if (v > longint'(vmax_uv)) v = vmax_uv;
      add_output(OK_VOLT, 3'(p), 8'd0, 23'(v), 1'b0, 8'd0);
    end
    add_output(OK_ENABLE, 3'd0, en_tbl[b], 23'd0, 1'b0, 8'd0);
    add_output(OK_ENABLE, 3'd0, en_tbl[b], 23'd0, 1'b0, 8'd0);
  endfunction

  function automatic void sequence_outputs(pump_request_t r);
    int cur;
    int nxt;
    logic [31:0] span;
    step_outputs.delete();
    case (r.kind)
      K_CLEAR: begin
        wipe_tables();
        add_shutdown();
      end
      K_ST_HDR: begin
        if (r.blk >= TABLE_BLOCKS) begin
          add_output(OK_ACK, 3'd0, 8'd0, 23'd0, 1'b1, loaded_n);
        end else begin
          dur_tbl[r.blk] = r.dur;
          dir_tbl[r.blk] = r.dir;
          en_tbl[r.blk]  = r.en;
          if (!valid_tbl[r.blk]) begin
            valid_tbl[r.blk] = 1'b1;
            loaded_n = loaded_n + 8'd1;
          end
          add_output(OK_ACK, 3'd0, 8'd0, 23'd0, 1'b0, loaded_n);
        end
      end
      K_ST_FLOW: begin
        if (r.blk >= TABLE_BLOCKS || r.pump >= PUMP_COUNT) begin
          add_output(OK_ACK, 3'd0, 8'd0, 23'd0, 1'b1, loaded_n);
        end else begin
          flow_tbl[r.blk * PUMP_COUNT + r.pump] = r.flow;
          add_output(OK_ACK, 3'd0, 8'd0, 23'd0, 1'b0, loaded_n);
        end
      end
      K_START: begin
        if (!valid_tbl[0]) begin
          seq_running = 1'b0;
        end else begin
          seq_running = 1'b1;
          seq_block   = 8'd0;
          seq_t0      = r.clock_ms;
          add_block_outputs(0);
        end
      end
      K_STOP: add_shutdown();
      K_TICK: begin
        if (seq_running) begin
          cur = seq_block;
          if (cur >= TABLE_BLOCKS || !valid_tbl[cur]) begin
            add_shutdown();
          end else begin
            span = dur_tbl[cur];
            if (span == 32'd0) span = 32'd1;
            // elapsed time wraps at 32 bits
            if (r.clock_ms - seq_t0 >= span) begin
              nxt = cur + 1;
              if (nxt >= TABLE_BLOCKS || !valid_tbl[nxt]) begin
                add_shutdown();
              end else begin
                seq_block = 8'(nxt);
                seq_t0    = r.clock_ms;
                add_block_outputs(nxt);
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (step_outputs.size() != 0) step_outputs[step_outputs.size() - 1].last = 1'b1;
  endfunction

  function automatic pump_request_t request_of(logic [2:0] k, logic [7:0] b, logic [3:0] p,
                                               logic [31:0] d, logic [7:0] dm,
                                               logic [7:0] em, logic [15:0] f,
                                               logic [31:0] t);
    pump_request_t r;
    r.kind     = k;
    r.blk      = b;
    r.pump     = p;
    r.dur      = d;
    r.dir      = dm;
    r.en       = em;
    r.flow     = f;
    r.clock_ms = t;
    return r;
  endfunction

  function automatic void add_directed(pump_request_t r, bit typed = 1'b0,
                                       logic st = 1'b0, logic [7:0] ld = 8'd0);
    directed_row_t row;
    row.req    = r;
    row.typed  = typed;
    row.status = st;
    row.loaded = ld;
    directed_rows.push_back(row);
  endfunction

  function automatic pump_request_t random_request();
    pump_request_t r;
    r.kind     = 3'($urandom_range(0, 7));
    r.blk      = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                             : 8'($urandom_range(0, TABLE_BLOCKS - 1));
    r.pump     = ($urandom_range(0, 1) != 0) ? 4'($urandom)
                                             : 4'($urandom_range(0, PUMP_COUNT - 1));
    r.dur      = $urandom();
    r.dir      = 8'($urandom);
    r.en       = 8'($urandom);
    r.flow     = 16'($urandom);
    r.clock_ms = $urandom();
    return r;
  endfunction

  function automatic logic [31:0] pick_duration();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($urandom_range(0, 4));
  endfunction

  function automatic logic [15:0] pick_flow();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 4500));
    endcase
  endfunction

  // Check each strobed output against the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output: out_kind %0d, pump_number %0d", out_kind, pump_number);
        mismatch_count++;
      end else begin
        want_out = pending_outputs.pop_front();
        if (out_kind !== want_out.kind) begin
          $error("out_kind: expected %0d, got %0d", want_out.kind, out_kind);
          mismatch_count++;
        end
        if (pump_number !== want_out.pump) begin
          $error("pump_number: expected %0d, got %0d", want_out.pump, pump_number);
          mismatch_count++;
        end
        if (byte_value !== want_out.byte_val) begin
          $error("byte_value: expected %0h, got %0h", want_out.byte_val, byte_value);
          mismatch_count++;
        end
        if (vout_uv !== want_out.uv) begin
          $error("vout_uv: expected %0d, got %0d", want_out.uv, vout_uv);
          mismatch_count++;
        end
        if (status !== want_out.status) begin
          $error("status: expected %0d, got %0d", want_out.status, status);
          mismatch_count++;
        end
        if (blocks_loaded !== want_out.loaded) begin
          $error("blocks_loaded: expected %0d, got %0d", want_out.loaded, blocks_loaded);
          mismatch_count++;
        end
        if (last !== want_out.last) begin
          $error("last: expected %0d, got %0d", want_out.last, last);
          mismatch_count++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request
  task automatic issue(pump_request_t r, bit typed = 1'b0, logic ack_status = 1'b0,
                       logic [7:0] ack_loaded = 8'd0);
    pump_output_t ack;
    if (!steady && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4))
        @(posedge clk);
    end
    start          <= 1'b1;
    kind           <= r.kind;
    slot_index     <= r.blk;
    pump_index     <= r.pump;
    hold_ms        <= r.dur;
    direction_mask <= r.dir;
    enable_mask    <= r.en;
    flow_value     <= r.flow;
    now_ms         <= r.clock_ms;
    do @(posedge clk); while (busy !== 1'b0);
    sequence_outputs(r);
    if (typed) begin
      ack        = '0;
      ack.kind   = OK_ACK;
      ack.status = ack_status;
      ack.loaded = ack_loaded;
      ack.last   = 1'b1;
      pending_outputs.push_back(ack);
    end else begin
      foreach (step_outputs[i]) pending_outputs.push_back(step_outputs[i]);
    end
    items_sent++;
  endtask

  // Drop start, drain expectations, then let silent requests finish
  task automatic settle_outputs();
    start <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] g, int o, logic [22:0] mn, logic [22:0] mx);
    cfg_write <= 1'b1;
    cfg_index <= REG_GAIN;
    cfg_data  <= {8'd0, g};
    @(posedge clk);
    cfg_index <= REG_OFFSET;
    cfg_data  <= o[23:0];
    @(posedge clk);
    cfg_index <= REG_VMIN;
    cfg_data  <= {1'b0, mn};
    @(posedge clk);
    cfg_index <= REG_VMAX;
    cfg_data  <= {1'b0, mx};
    @(posedge clk);
    cfg_write <= 1'b0;
    gain_uv   = g;
    offset_uv = o;
    vmin_uv   = mn;
    vmax_uv   = mx;
  endtask

  // Maybe clear, load one to five blocks from slot 0 and some flows, start, then tick through them
  task automatic run_program();
    pump_request_t r;
    int nb;
    int b;
    logic [31:0] t;
    if ($urandom_range(0, 2) == 0) begin
      r = random_request();
      r.kind = K_CLEAR;
      issue(r);
    end
    nb = $urandom_range(1, 5);
    for (b = 0; b < nb; b++) begin
      r = random_request();
      r.kind = K_ST_HDR;
      r.blk  = 8'(b);
      r.dur  = pick_duration();
      issue(r);
    end
    repeat ($urandom_range(2, 10)) begin
      r = random_request();
      r.kind = K_ST_FLOW;
      r.blk  = 8'($urandom_range(0, nb));
      r.pump = 4'($urandom_range(0, PUMP_COUNT - 1));
      r.flow = pick_flow();
      issue(r);
    end
    if ($urandom_range(0, 3) == 0) begin
      r = random_request();
      r.kind = ($urandom_range(0, 1) != 0) ? K_ST_HDR : K_ST_FLOW;
      r.blk  = 8'($urandom_range(TABLE_BLOCKS, 255));
      issue(r);
    end
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 6) : $urandom();
    r = random_request();
    r.kind     = K_START;
    r.clock_ms = t;
    issue(r);
    repeat ($urandom_range(4, 14)) begin
      t = t + $urandom_range(0, 3);
      r = random_request();
      case ($urandom_range(0, 15))
        0: r.kind = K_STOP;
        1: r.kind = K_START;
        default: r.kind = K_TICK;
      endcase
      r.clock_ms = t;
      issue(r);
    end
  endtask

  // Fill every slot and walk off the end of the table
  task automatic run_full_table();
    pump_request_t r;
    int b;
    logic [31:0] t;
    r = random_request();
    r.kind = K_CLEAR;
    issue(r);
    for (b = 0; b < TABLE_BLOCKS; b++) begin
      r = random_request();
      r.kind = K_ST_HDR;
      r.blk  = 8'(b);
      r.dur  = 32'($urandom_range(0, 2));
      issue(r);
    end
    repeat (8) begin
      r = random_request();
      r.kind = K_ST_FLOW;
      r.blk  = 8'($urandom_range(0, TABLE_BLOCKS - 1));
      r.pump = 4'($urandom_range(0, PUMP_COUNT - 1));
      r.flow = pick_flow();
      issue(r);
    end
    t = $urandom();
    r = random_request();
    r.kind     = K_START;
    r.clock_ms = t;
    issue(r);
    for (b = 0; b < TABLE_BLOCKS; b++) begin
      t = t + $urandom_range(2, 3);
      r = random_request();
      r.kind     = K_TICK;
      r.clock_ms = t;
      issue(r);
    end
  endtask

  task automatic run_phase(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) issue(random_request());
      end else begin
        run_program();
      end
    end
    settle_outputs();
  endtask

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("timed_pump_block_sequencer test failed");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    kind           <= '0;
    slot_index     <= '0;
    pump_index     <= '0;
    hold_ms        <= '0;
    direction_mask <= '0;
    enable_mask    <= '0;
    flow_value     <= '0;
    now_ms         <= '0;
    cfg_write      <= 1'b0;
    cfg_index      <= REG_GAIN;
    cfg_data       <= '0;

    wipe_tables();
    seq_running = 1'b0;
    seq_block   = '0;
    seq_t0      = '0;
    gain_uv     = GAIN_RST;
    offset_uv   = OFFSET_RST;
    vmin_uv     = VMIN_RST;
    vmax_uv     = VMAX_RST;

    add_directed(request_of(K_TICK, 0, 0, 0, 0, 0, 0, 0));
    add_directed(request_of(K_START, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    add_directed(request_of(K_ST_FLOW, 0, 7, 0, 0, 0, 16'hFFFF, 0), 1'b1, 1'b0, 8'd0);
    add_directed(request_of(K_ST_FLOW, 8'hFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                            32'hFFFF_FFFF), 1'b1, 1'b1, 8'd0);
    add_directed(request_of(K_ST_FLOW, 0, 8, 0, 0, 0, 16'd100, 0), 1'b1, 1'b1, 8'd0);
    add_directed(request_of(K_ST_HDR, 64, 0, 5, 8'hFF, 8'hFF, 0, 0), 1'b1, 1'b1, 8'd0);
    add_directed(request_of(K_ST_HDR, 0, 0, 0, 8'hFF, 8'hFF, 0, 0), 1'b1, 1'b0, 8'd1);
    // rewrite of a valid slot keeps the count
    add_directed(request_of(K_ST_HDR, 0, 0, 0, 8'hA5, 8'h5A, 0, 0), 1'b1, 1'b0, 8'd1);
    add_directed(request_of(K_ST_HDR, 63, 0, 32'hFFFF_FFFF, 0, 0, 0, 0), 1'b1, 1'b0, 8'd2);
    add_directed(request_of(K_ST_HDR, 1, 0, 3, 8'h3C, 8'hC3, 0, 0), 1'b1, 1'b0, 8'd3);
    add_directed(request_of(K_ST_FLOW, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 8'd3);
    add_directed(request_of(K_ST_FLOW, 1, 3, 0, 0, 0, 16'd4000, 0), 1'b1, 1'b0, 8'd3);
    add_directed(request_of(K_ST_FLOW, 1, 5, 0, 0, 0, 16'd1000, 0), 1'b1, 1'b0, 8'd3);
    add_directed(request_of(K_START, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    add_directed(request_of(K_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    // time wraps past zero and the zero duration block ends
    add_directed(request_of(K_TICK, 0, 0, 0, 0, 0, 0, 0));
    add_directed(request_of(K_TICK, 0, 0, 0, 0, 0, 0, 2));
    add_directed(request_of(K_TICK, 0, 0, 0, 0, 0, 0, 3));
    add_directed(request_of(KIND_SPARE_LO, 0, 0, 0, 0, 0, 0, 0));
    add_directed(request_of(KIND_SPARE_HI, 8'hFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                            32'hFFFF_FFFF));
    add_directed(request_of(K_START, 0, 0, 0, 0, 0, 0, 5));
    add_directed(request_of(K_STOP, 0, 0, 0, 0, 0, 0, 0));
    add_directed(request_of(K_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    add_directed(request_of(K_ST_HDR, 62, 0, 7, 8'h81, 8'h18, 0, 0), 1'b1, 1'b0, 8'd1);
    add_directed(request_of(K_START, 0, 0, 0, 0, 0, 0, 9));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].status,
            directed_rows[i].loaded);
    settle_outputs();
    run_phase(40);

    load_settings(16'hFFFF, 5000000, 23'd0, 23'd5000000);
    steady = 1'b1;
    run_phase(35);
    steady = 1'b0;

    // crossed limits
    load_settings(16'd0, -5000000, 23'd5000000, 23'd0);
    run_phase(25);

    load_settings(16'($urandom_range(500, 2000)), int'($urandom_range(0, 400000)) - 200000,
                  23'($urandom_range(0, 500000)), 23'($urandom_range(3000000, 5000000)));
    run_full_table();
    run_phase(10);

    load_settings(16'($urandom_range(0, 3000)), int'($urandom_range(0, 10000000)) - 5000000,
                  23'($urandom_range(0, 5000000)), 23'($urandom_range(0, 5000000)));
    run_phase(35);

    if (mismatch_count == 0) begin
      $display("timed_pump_block_sequencer test passed");
    end else begin
      $display("timed_pump_block_sequencer test failed");
    end
    $finish;
  end

endmodule
